[hw/rtl/msa_pkg.sv]
// Shared types and constants for the moving average ring unit.
// Used by msa_div_serial, moving_average_ring_unit and msa_checker.
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

  // Field widths
  localparam int SMP_W   = 16;                 // input sample
  localparam int AVG_W   = 16;                 // average result
  localparam int CNT_W   = 7;                  // window length and fill count
  localparam int WIN_MAX = (1 << CNT_W) - 1;   // largest length the register can hold

  // Result stream packing: average, then filled, zero pad to whole bytes
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - AVG_W - CNT_W;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEP_W = $clog2(AVG_W);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic [CFG_AW-3:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW_LENGTH = '0;

  localparam logic [CNT_W-1:0] WIN_LEN_RESET = 7'd8;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [AVG_W-1:0] avg_t;

endpackage

`default_nettype wire

[hw/rtl/moving_average_ring_unit.sv]
// Moving average ring unit: top level with sample ring, running sum and control.
// Depends on msa_pkg, msa_ram and msa_div_serial.
//
// Usage:
//   Input stream (in_*): one 16-bit sample per transaction.
//   Result stream (out_*): one transaction per sample carrying the truncated
//   mean of the held samples and the number held (saturating at the window).
//   APB port: register 0 at address 0 is window_length. Writing it restarts
//   averaging (fill count, sum and ring pointer cleared); write it only while
//   no sample is in flight. Length 0 acts as 1, beyond the ring as its depth.
// Timing:
//   One sample at a time. An accepted sample passes through sum update, divider
//   load, the bit-serial divide of all 16 quotient bits (which sets the rate),
//   divider done and output register load. The next sample is not accepted until
//   that result is loaded; it can be accepted from the cycle the result appears.
//   A stalled receiver does not block acceptance until a second result is
//   ready; then the block holds until out_tready.
// Reset:
//   rst_n is synchronous. It empties the window and sets window_length to 8.
//   Ring contents are not cleared; an entry's read data is only used after it is written.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_ring_unit #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input stream
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [msa_pkg::SMP_W-1:0]     in_tdata,   // [15:0] sample
  // Result stream
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [msa_pkg::OUT_TDATA_W-1:0] out_tdata, // [15:0] average, [22:16] filled
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [msa_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [msa_pkg::CFG_DW-1:0]    pwdata,
  output      logic [msa_pkg::CFG_DW-1:0]    prdata,
  output      logic                          pready
);
  import msa_pkg::*;

  localparam int MAX_LEN = (RING_DEPTH < WIN_MAX) ? RING_DEPTH : WIN_MAX;
  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int SUM_W   = SMP_W + $clog2(MAX_LEN);
  localparam int CW      = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam cnt_t MAX_LEN_C = CNT_W'(MAX_LEN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  cnt_t               win_len_r, win_len_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  cnt_t               held_r, held_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SMP_W-1:0]   smp_r, smp_nxt;
  avg_t               out_avg_r, out_avg_nxt;
  cnt_t               out_cnt_r, out_cnt_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;

  cnt_t               eff_len;
  logic [IDX_W-1:0]   idx_start;
  logic [IDX_W-1:0]   idx_next;
  logic [CW-1:0]      idx_inc;
  logic               full;
  logic               in_acc;
  logic               cfg_wr;
  logic               cfg_hit;
  logic [SMP_W-1:0]   ram_rdata;
  logic               div_start;
  logic               div_done;
  avg_t               div_q;

  // Handshakes
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[CFG_AW-1:2] == REG_WINDOW_LENGTH);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = cfg_hit ? CFG_DW'(win_len_r) : '0;

  // Effective window length: at least one, at most the ring depth
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (win_len_r > MAX_LEN_C) begin
      eff_len = MAX_LEN_C;
    end else begin
      eff_len = win_len_r;
    end
  end

  // Ring pointer arithmetic
  assign idx_start = (CW'(wr_idx_r) >= CW'(eff_len)) ? '0 : wr_idx_r;
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign idx_next  = (idx_inc >= CW'(eff_len)) ? '0 : idx_r + IDX_W'(1);
  assign full      = (held_r >= eff_len);

  // Sample ring: read the slot at acceptance, overwrite it on the update cycle
  msa_ram #(
    .WIDTH (SMP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (idx_r),
    .wdata (smp_r),
    .re    (in_acc),
    .raddr (idx_start),
    .rdata (ram_rdata)
  );

  // Sum over count
  assign div_start = (state_r == S_DIV_GO);

  msa_div_serial #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (held_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control and window state
  always_comb begin
    state_nxt      = state_r;
    win_len_nxt    = win_len_r;
    wr_idx_nxt     = wr_idx_r;
    idx_nxt        = idx_r;
    held_nxt       = held_r;
    sum_nxt        = sum_r;
    smp_nxt        = smp_r;
    out_avg_nxt    = out_avg_r;
    out_cnt_nxt    = out_cnt_r;
    out_tvalid_nxt = out_tvalid_r;

    // Result register drains independently of the pipeline
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_wr && cfg_hit) begin
          win_len_nxt = pwdata[CNT_W-1:0];
          wr_idx_nxt  = '0;
          held_nxt    = '0;
          sum_nxt     = '0;
        end
        if (in_acc) begin
          smp_nxt   = in_tdata;
          idx_nxt   = idx_start;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // Oldest sample leaves once the window is full
        sum_nxt    = sum_r - (full ? SUM_W'(ram_rdata) : '0) + SUM_W'(smp_r);
        held_nxt   = full ? eff_len : held_r + CNT_W'(1);
        wr_idx_nxt = idx_next;
        state_nxt  = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_avg_nxt    = div_q;
          out_cnt_nxt    = held_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_len_r    <= WIN_LEN_RESET;
      wr_idx_r     <= '0;
      held_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      win_len_r    <= win_len_nxt;
      wr_idx_r     <= wr_idx_nxt;
      held_r       <= held_nxt;
      sum_r        <= sum_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r     <= idx_nxt;
    smp_r     <= smp_nxt;
    out_avg_r <= out_avg_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_avg_r};

endmodule

`default_nettype wire

[hw/rtl/msa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/msa_div_serial.sv]
// Bit-serial restoring divider: running sum over fill count, one quotient bit per cycle.
// Depends on msa_pkg. The quotient is known to fit in AVG_W bits.
`timescale 1ns / 1ps
`default_nettype none

module msa_div_serial #(
  parameter int SUM_W = 22
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire msa_pkg::cnt_t      divisor,
  output      logic               done,
  output      msa_pkg::avg_t      quotient
);
  import msa_pkg::*;

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_t;

  localparam logic [DIV_STEP_W-1:0] STEP_LAST = DIV_STEP_W'(AVG_W - 1);

  div_state_t            state_r, state_nxt;
  cnt_t                  rem_r, rem_nxt;
  cnt_t                  dvs_r, dvs_nxt;
  avg_t                  q_r, q_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic                  done_r, done_nxt;

  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        diff;
  logic                  ge;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, q_r[AVG_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          // Upper dividend bits are already below the divisor
          rem_nxt   = CNT_W'(dividend[SUM_W-1:AVG_W]);
          q_nxt     = dividend[AVG_W-1:0];
          dvs_nxt   = divisor;
          step_nxt  = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        q_nxt    = {q_r[AVG_W-2:0], ge};
        step_nxt = step_r + DIV_STEP_W'(1);
        if (step_r == STEP_LAST) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      step_r  <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

[hw/rtl/msa_checker.sv]
// Port-level checks for moving_average_ring_unit, attached by bind.
// Depends on msa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msa_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [msa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import msa_pkg::*;

  // A held result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One sample at a time: no acceptance right after an acceptance
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample accepted while one is in flight");

  // Every result covers at least one sample
  a_filled_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[AVG_W+CNT_W-1:AVG_W] != '0)
    else $error("result with empty window");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind moving_average_ring_unit msa_checker u_msa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for moving_average_ring_unit.
// Drives samples and window writes, predicts each mean in-bench and checks every result.
// Depends on msa_pkg and the moving_average_ring_unit RTL.
`timescale 1ns / 1ps

module tb;
  import msa_pkg::*;

  localparam int RING_DEPTH    = 64;
  localparam int RAND_PER_MODE = 275;   // three idle modes, about 825 random samples
  localparam int LONG_HOLD     = 300;   // receiver hold-off, in cycles
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CFG_AW-1:0] ADDR_WINDOW_LENGTH = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED        = 3'd4;   // no register here

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] value;
    bit                typed;    // expectation typed in below
    avg_t              avg;
    cnt_t              filled;
  } stim_row_t;

  typedef struct {
    avg_t avg;
    cnt_t filled;
  } window_result_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [SMP_W-1:0]       in_tdata = '0;        // [15:0] sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;            // [15:0] average, [22:16] filled
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [CFG_DW-1:0]      pwdata = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  // Window model state
  logic [SMP_W-1:0] held_samples [RING_DEPTH];
  cnt_t             win_len = WIN_LEN_RESET;
  logic [5:0]       next_slot = '0;
  int unsigned      fill_count = 0;
  int unsigned      window_sum = 0;

  window_result_t pending_means[$];
  stim_row_t      directed_rows[$];

  int fail_count    = 0;
  int snd_idle_pct  = 24;
  int rcv_idle_pct  = 61;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int hold_left     = 0;

  moving_average_ring_unit #(.RING_DEPTH(RING_DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  // Push one sample into the model window and return the resulting mean
  function automatic window_result_t window_push(input logic [SMP_W-1:0] s);
    window_result_t r;
    int unsigned    eff;
    int unsigned    slot;
    eff = win_len;
    if (eff < 1) eff = 1;
    if (eff > RING_DEPTH) eff = RING_DEPTH;
    slot = next_slot;
    if (slot >= eff) slot = 0;
    // full window: drop the oldest sample first
    if (fill_count >= eff) begin
      window_sum = window_sum - held_samples[slot];
      fill_count = eff;
    end else begin
      fill_count++;
    end
    held_samples[slot] = s;
    window_sum = window_sum + s;
    slot++;
    if (slot >= eff) slot = 0;
    next_slot = slot[5:0];
    r.avg    = avg_t'(window_sum / fill_count);
    r.filled = cnt_t'(fill_count);
    return r;
  endfunction

  function automatic void dir_sample(input logic [SMP_W-1:0] s, input bit typed,
                                     input avg_t avg, input cnt_t filled);
    stim_row_t row;
    row.kind = ROW_SAMPLE; row.addr = '0; row.value = CFG_DW'(s);
    row.typed = typed; row.avg = avg; row.filled = filled;
    directed_rows.push_back(row);
  endfunction

  function automatic void dir_write(input logic [CFG_AW-1:0] addr,
                                    input logic [CFG_DW-1:0] value);
    stim_row_t row;
    row.kind = ROW_WRITE; row.addr = addr; row.value = value;
    row.typed = 1'b0; row.avg = '0; row.filled = '0;
    directed_rows.push_back(row);
  endfunction

  // One sample transaction; the model runs at acceptance
  task automatic send_sample(input logic [SMP_W-1:0] s, input bit typed,
                             input avg_t t_avg, input cnt_t t_filled);
    window_result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = window_push(s);
    if (typed) begin
      r.avg    = t_avg;
      r.filled = t_filled;
    end
    pending_means.push_back(r);
  endtask

  // Stop offering samples and let every result come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup, then access; any window write restarts the average
  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WINDOW_LENGTH) begin
      win_len    = data[CNT_W-1:0];
      next_slot  = '0;
      fill_count = 0;
      window_sum = 0;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen = hold_off_reqs;
      hold_left     = LONG_HOLD - 1;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    window_result_t want;
    avg_t           got_avg;
    cnt_t           got_filled;
    if (rst_n && out_tvalid && out_tready) begin
      got_avg    = out_tdata[AVG_W-1:0];
      got_filled = out_tdata[AVG_W +: CNT_W];
      if (pending_means.size() == 0) begin
        note_failure($sformatf("unexpected result: average %0d filled %0d",
                               got_avg, got_filled));
      end else begin
        want = pending_means.pop_front();
        if (got_avg !== want.avg || got_filled !== want.filled)
          note_failure($sformatf("mismatch: average exp %0d got %0d, filled exp %0d got %0d",
                                 want.avg, got_avg, want.filled, got_filled));
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("** moving_average_ring_unit: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t        row;
    cnt_t             wl;
    logic [CFG_DW-1:0] wdata;
    logic [SMP_W-1:0] s;
    int               eff;
    int               n;
    int               items_left;
    int               guard;

    foreach (held_samples[i]) held_samples[i] = '0;

    // Directed rows; window length is 8 after reset
    dir_sample(16'hFFFF, 1, 16'hFFFF, 7'd1);
    dir_sample(16'h0000, 1, 16'h7FFF, 7'd2);
    dir_sample(16'h0001, 0, '0, '0);
    dir_sample(16'h5555, 0, '0, '0);
    // zero length acts as one: each sample replaces the last
    dir_write(ADDR_WINDOW_LENGTH, 32'd0);
    dir_sample(16'h1234, 1, 16'h1234, 7'd1);
    dir_sample(16'hABCD, 1, 16'hABCD, 7'd1);
    // length beyond the ring acts as the ring depth
    dir_write(ADDR_WINDOW_LENGTH, 32'd127);
    dir_sample(16'hFFFF, 1, 16'hFFFF, 7'd1);
    dir_sample(16'hFFFF, 1, 16'hFFFF, 7'd2);
    dir_sample(16'h8000, 0, '0, '0);
    dir_write(ADDR_WINDOW_LENGTH, 32'd2);
    dir_sample(16'd100, 1, 16'd100, 7'd1);
    dir_sample(16'd300, 1, 16'd200, 7'd2);
    dir_sample(16'd500, 1, 16'd400, 7'd2);
    // write to an unused address leaves the window alone
    dir_write(ADDR_UNUSED, 32'd1);
    dir_sample(16'd700, 1, 16'd600, 7'd2);
    // rewriting the same length still restarts the average
    dir_write(ADDR_WINDOW_LENGTH, 32'd2);
    dir_sample(16'd7, 1, 16'd7, 7'd1);
    // upper data bits are dropped: length 3, then wrap around
    dir_write(ADDR_WINDOW_LENGTH, 32'hFFFF_FF83);
    dir_sample(16'hAAAA, 0, '0, '0);
    dir_sample(16'h5555, 0, '0, '0);
    dir_sample(16'h0F0F, 0, '0, '0);
    dir_sample(16'hF0F0, 0, '0, '0);
    dir_write(ADDR_WINDOW_LENGTH, 32'd64);
    dir_sample(16'h0000, 1, 16'h0000, 7'd1);
    dir_sample(16'hFFFF, 1, 16'h7FFF, 7'd2);
    dir_write(ADDR_WINDOW_LENGTH, 32'd8);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        apb_write(row.addr, row.value);
      end else begin
        send_sample(row.value[SMP_W-1:0], row.typed, row.avg, row.filled);
      end
    end

    // Random phases under three idle patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin snd_idle_pct = 24; rcv_idle_pct = 61; end
        1: begin snd_idle_pct = 61; rcv_idle_pct = 24; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      items_left = RAND_PER_MODE;
      while (items_left > 0) begin
        wait_drained();
        case ($urandom_range(9))
          0:       wl = 7'd0;
          1:       wl = 7'd1;
          2:       wl = 7'd64;
          3:       wl = cnt_t'($urandom_range(127, 65));
          4:       wl = cnt_t'($urandom_range(127));
          default: wl = cnt_t'($urandom_range(8, 1));
        endcase
        wdata = $urandom;
        wdata[CNT_W-1:0] = wl;
        apb_write(ADDR_WINDOW_LENGTH, wdata);
        if ($urandom_range(3) == 0) apb_write(ADDR_UNUSED, $urandom);
        eff = (wl == 0) ? 1 : (wl > RING_DEPTH) ? RING_DEPTH : wl;
        n = (eff >= 32) ? eff + $urandom_range(40, 10) : $urandom_range(40, 8);
        if (n > items_left) n = items_left;
        // one long receiver hold-off per mode while samples keep coming
        if (items_left == RAND_PER_MODE) hold_off_reqs++;
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(7))
            0:       s = 16'h0000;
            1:       s = 16'hFFFF;
            2:       s = SMP_W'($urandom_range(15));
            3:       s = 16'hFFF0 | SMP_W'($urandom_range(15));
            default: s = SMP_W'($urandom);
          endcase
          send_sample(s, 0, '0, '0);
        end
        items_left -= n;
      end
    end

    // Drain and finish
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_means.size() != 0 && guard < DRAIN_LIMIT) begin
      guard++;
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (pending_means.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_means.size()));
    if (fail_count == 0) begin
      $display("** moving_average_ring_unit: PASSED **");
    end else begin
      $display("** moving_average_ring_unit: FAILED **");
    end
    $finish;
  end

endmodule
